[rtl/core/pse_pkg.sv]
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, constants and decode helpers for the postfix stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int WORD_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [PTR_W-1:0] PTR_ZERO = '0;
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
  localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(STACK_DEPTH);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_CARET = 8'h5e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNSUP = 2'd1;
  localparam logic [1:0] ST_DIV0  = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;

  localparam logic [WORD_W-1:0] WORD_NEG_ONE = '1;
  localparam logic [WORD_W-1:0] WORD_ONE     = WORD_W'(1);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_SLASH) ||
           (c == CH_STAR) || (c == CH_CARET);
  endfunction

  function automatic op_t char_to_op(input logic [7:0] c);
    op_t op;
    priority case (c)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      default:  op = OP_POW;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

[rtl/core/pse_ram.sv]
// ----------------------------------------------------------------------------
// pse_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/pse_alu.sv]
// ----------------------------------------------------------------------------
// pse_alu
// Shared arithmetic unit: add and subtract in one step, multiply and power by
// square-and-multiply, truncating signed division by restoring shift-subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_alu import pse_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire alu_req_t          req,
  input  wire logic [WORD_W-1:0] a,
  input  wire logic [WORD_W-1:0] b,
  output logic      [WORD_W-1:0] result,
  output alu_rsp_t               rsp
);

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_DIV  = 5'b00010,
    A_FIX  = 5'b00100,
    A_POW  = 5'b01000,
    A_DONE = 5'b10000
  } alu_state_t;

  alu_state_t        state;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] base;
  logic [WORD_W-1:0] ex;
  logic [WORD_W-1:0] rem;
  logic [4:0]        cnt;
  logic              neg;
  logic              dz;

  logic [WORD_W-1:0] prod_rb;
  logic [WORD_W-1:0] prod_bb;
  logic [WORD_W-1:0] mag_a;
  logic [WORD_W-1:0] mag_b;
  logic [WORD_W-1:0] pow_neg;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W+1:0] diff;
  logic              borrow;

  always_comb begin
    prod_rb = acc * base;
    prod_bb = base * base;
    mag_a   = a[WORD_W-1] ? (WORD_W'(0) - a) : a;
    mag_b   = b[WORD_W-1] ? (WORD_W'(0) - b) : b;
    rem_sh  = {rem, acc[WORD_W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, base};
    borrow  = diff[WORD_W+1];
    // negative exponent: only bases one and minus one survive truncation
    if (a == WORD_ONE) begin
      pow_neg = WORD_ONE;
    end else if (a == WORD_NEG_ONE) begin
      pow_neg = b[0] ? WORD_NEG_ONE : WORD_ONE;
    end else begin
      pow_neg = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            dz <= 1'b0;
            unique case (req.op)
              OP_ADD: begin
                acc   <= a + b;
                state <= A_DONE;
              end
              OP_SUB: begin
                acc   <= a - b;
                state <= A_DONE;
              end
              OP_MUL: begin
                // one pass of the power loop with exponent one
                acc   <= a;
                base  <= b;
                ex    <= WORD_ONE;
                state <= A_POW;
              end
              OP_POW: begin
                if (b[WORD_W-1]) begin
                  acc   <= pow_neg;
                  dz    <= (a == '0);
                  state <= A_DONE;
                end else begin
                  acc   <= WORD_ONE;
                  base  <= a;
                  ex    <= b;
                  state <= A_POW;
                end
              end
              OP_DIV: begin
                if (b == '0) begin
                  acc   <= '0;
                  dz    <= 1'b1;
                  state <= A_DONE;
                end else begin
                  rem   <= '0;
                  acc   <= mag_a;
                  base  <= mag_b;
                  neg   <= a[WORD_W-1] ^ b[WORD_W-1];
                  cnt   <= '0;
                  state <= A_DIV;
                end
              end
              default: begin
                acc   <= '0;
                state <= A_DONE;
              end
            endcase
          end
        end
        A_DIV: begin
          rem <= borrow ? rem_sh[WORD_W-1:0] : diff[WORD_W-1:0];
          acc <= {acc[WORD_W-2:0], ~borrow};
          cnt <= cnt + 5'd1;
          if (cnt == '1) begin
            state <= A_FIX;
          end
        end
        A_FIX: begin
          if (neg) begin
            acc <= WORD_W'(0) - acc;
          end
          state <= A_DONE;
        end
        A_POW: begin
          if (ex == '0) begin
            state <= A_DONE;
          end else begin
            if (ex[0]) begin
              acc <= prod_rb;
            end
            base <= prod_bb;
            ex   <= {1'b0, ex[WORD_W-1:1]};
          end
        end
        A_DONE: begin
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  assign result       = acc;
  assign rsp.done     = (state == A_DONE);
  assign rsp.div_zero = dz;

endmodule

`default_nettype wire

[rtl/core/postfix_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Evaluates a postfix expression fed one character per transaction over a
// signed 32-bit operand stack held in RAM; emits top of stack and status on
// the character marked last.
// ----------------------------------------------------------------------------
//
//   channel | signals                               | dir | transaction
//   --------+---------------------------------------+-----+---------------------
//   in      | in_valid, in_ready, character, last   | in  | one expression char
//   out     | out_valid, out_ready, value, status   | out | one result per expr
//
// A digit is pushed in decode; an operator pops two operands and waits on the
// shared unit (32-step restoring divider, one square-and-multiply step per
// exponent bit). The character marked last adds a stack top read.
// in_ready is high only while the sequencer is idle; a result waiting in the
// output register stalls only the next last character, not earlier ones.
// Synchronous reset empties the stack, clears the error state and drops
// out_valid; RAM contents and the value and status outputs are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_stack_evaluator import pse_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        character,
  input  wire logic              last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [WORD_W-1:0] value,
  output logic      [1:0]        status
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_RD1    = 7'b0000100,
    S_RD2    = 7'b0001000,
    S_CALC   = 7'b0010000,
    S_TOPRD  = 7'b0100000,
    S_TOPCAP = 7'b1000000
  } state_t;

  state_t            state;
  state_t            fin_state;
  logic [7:0]        char_q;
  logic              last_q;
  logic [PTR_W-1:0]  top;
  logic [PTR_W-1:0]  top_dec;
  logic [1:0]        err;
  logic              halted;
  logic              pop_ok;
  logic [WORD_W-1:0] n1;
  logic [WORD_W-1:0] n2;

  logic              ram_we;
  logic              ram_re;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [WORD_W-1:0] alu_result;

  logic              c_digit;
  logic              c_oper;
  logic              full;
  logic              empty;
  logic              out_load;

  assign c_digit   = is_digit(char_q);
  assign c_oper    = is_operator(char_q);
  assign full      = (top == PTR_FULL);
  assign empty     = (top == PTR_ZERO);
  assign top_dec   = top - PTR_ONE;
  assign fin_state = last_q ? S_TOPRD : S_IDLE;
  assign in_ready  = (state == S_IDLE);
  assign out_load  = (state == S_TOPCAP) && (!out_valid || out_ready);
  assign n2        = pop_ok ? ram_rdata : WORD_NEG_ONE;

  assign alu_req.start = (state == S_RD2);
  assign alu_req.op    = char_to_op(char_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = {{(WORD_W-8){1'b0}}, char_q - CH_ZERO};
    unique case (state)
      S_DECODE: begin
        ram_we = !halted && c_digit && !full;
        ram_re = !halted && c_oper && !empty;
      end
      S_RD1: begin
        ram_re = !empty;
      end
      S_CALC: begin
        ram_we    = alu_rsp.done && !full;
        ram_wdata = alu_result;
      end
      S_TOPRD: begin
        ram_re = !empty;
      end
      default: begin
      end
    endcase
  end

  pse_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(top[ADDR_W-1:0]),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(top_dec[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  pse_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .req   (alu_req),
    .a     (n2),
    .b     (n1),
    .result(alu_result),
    .rsp   (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      top       <= PTR_ZERO;
      err       <= ST_OK;
      halted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            char_q <= character;
            last_q <= last;
            state  <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (halted) begin
            state <= fin_state;
          end else if (c_digit) begin
            if (full) begin
              if (err == ST_OK) begin
                err <= ST_OVF;
              end
            end else begin
              top <= top + PTR_ONE;
            end
            state <= fin_state;
          end else if (c_oper) begin
            pop_ok <= !empty;
            if (!empty) begin
              top <= top_dec;
            end
            state <= S_RD1;
          end else begin
            // unsupported character overrides any earlier error
            halted <= 1'b1;
            err    <= ST_UNSUP;
            state  <= fin_state;
          end
        end
        S_RD1: begin
          n1     <= pop_ok ? ram_rdata : WORD_NEG_ONE;
          pop_ok <= !empty;
          if (!empty) begin
            top <= top_dec;
          end
          state <= S_RD2;
        end
        S_RD2: begin
          state <= S_CALC;
        end
        S_CALC: begin
          if (alu_rsp.done) begin
            // divide by zero is raised before the push can overflow
            if (err == ST_OK) begin
              if (alu_rsp.div_zero) begin
                err <= ST_DIV0;
              end else if (full) begin
                err <= ST_OVF;
              end
            end
            if (!full) begin
              top <= top + PTR_ONE;
            end
            state <= fin_state;
          end
        end
        S_TOPRD: begin
          state <= S_TOPCAP;
        end
        S_TOPCAP: begin
          if (out_load) begin
            out_valid <= 1'b1;
            value     <= (halted || empty) ? WORD_NEG_ONE : ram_rdata;
            status    <= err;
            top       <= PTR_ZERO;
            err       <= ST_OK;
            halted    <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // stack pointer never passes the stack depth
  a_top_range: assert property (@(posedge clk) disable iff (rst)
    top <= PTR_FULL)
    else $error("stack pointer beyond depth");

  // the shared unit only finishes while the sequencer waits for it
  a_alu_done: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> state == S_CALC)
    else $error("alu finished outside calc state");

  // emitting a result leaves an empty, error-free stack
  a_clear: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (empty && err == ST_OK && !halted))
    else $error("stack not cleared after result");

  // an unsupported character always reports minus one
  a_unsup_val: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_UNSUP) |-> value == -32'sd1)
    else $error("unsupported status with value other than -1");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives postfix expressions into the evaluator one character per transaction
// and checks each result against a cycle-free model of the operand stack.
// Directed expressions cover every operator and the corner cases. Random
// expression trees, stack overflows, bad characters and noise then follow,
// with random idle gaps on both, one or neither channel by segment.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pse_pkg::*;

  localparam int ITEM_TARGET  = 1750;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int REPORT_CAP   = 40;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [1:0]        status;
  } eval_t;

  function automatic bit is_digit_char(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic bit is_op_char(logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_SLASH) ||
           (c == CH_STAR) || (c == CH_CARET);
  endfunction

  class postfix_tracker;
    logic [WORD_W-1:0] words [STACK_DEPTH];
    int                fill;
    logic [1:0]        err;
    bit                halted;
    eval_t             awaited[$];
    int                errors;

    function new();
      fill   = 0;
      err    = ST_OK;
      halted = 1'b0;
      errors = 0;
    endfunction

    function void flag(logic [1:0] code);
      if (err == ST_OK) err = code;
    endfunction

    function void push_operand(logic [WORD_W-1:0] v);
      if (fill >= STACK_DEPTH) begin
        flag(ST_OVF);
        return;
      end
      words[fill] = v;
      fill++;
    endfunction

    function logic [WORD_W-1:0] pop_operand();
      if (fill == 0) return WORD_NEG_ONE;
      fill--;
      return words[fill];
    endfunction

    // truncating division on magnitudes, divisor nonzero
    function logic [WORD_W-1:0] quotient(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
      logic [WORD_W-1:0] ma, mb, q;
      ma = a[WORD_W-1] ? -a : a;
      mb = b[WORD_W-1] ? -b : b;
      q  = ma / mb;
      return (a[WORD_W-1] ^ b[WORD_W-1]) ? -q : q;
    endfunction

    function logic [WORD_W-1:0] raise(logic [WORD_W-1:0] base, logic [WORD_W-1:0] ex,
                                      output bit zero_neg);
      logic [WORD_W-1:0] acc, sq, e;
      zero_neg = 1'b0;
      if (ex[WORD_W-1]) begin
        if (base == WORD_ONE) return WORD_ONE;
        if (base == WORD_NEG_ONE) return ex[0] ? WORD_NEG_ONE : WORD_ONE;
        if (base == '0) zero_neg = 1'b1;
        return '0;
      end
      acc = WORD_ONE;
      sq  = base;
      e   = ex;
      while (e != '0) begin
        if (e[0]) acc = acc * sq;
        sq = sq * sq;
        e  = e >> 1;
      end
      return acc;
    endfunction

    function void note_char(logic [7:0] c, logic is_last);
      logic [WORD_W-1:0] n1, n2, r;
      bit                bad;
      eval_t             res;
      if (!halted) begin
        if (is_digit_char(c)) begin
          push_operand(WORD_W'(c - CH_ZERO));
        end else if (is_op_char(c)) begin
          n1 = pop_operand();
          n2 = pop_operand();
          case (c)
            CH_PLUS:  r = n2 + n1;
            CH_MINUS: r = n2 - n1;
            CH_STAR:  r = n2 * n1;
            CH_SLASH: begin
              if (n1 == '0) begin
                flag(ST_DIV0);
                r = '0;
              end else begin
                r = quotient(n2, n1);
              end
            end
            default: begin
              r = raise(n2, n1, bad);
              if (bad) flag(ST_DIV0);
            end
          endcase
          push_operand(r);
        end else begin
          halted = 1'b1;
          err    = ST_UNSUP;
        end
      end
      if (is_last) begin
        res.value  = (halted || fill == 0) ? WORD_NEG_ONE : words[fill-1];
        res.status = err;
        awaited.push_back(res);
        fill   = 0;
        err    = ST_OK;
        halted = 1'b0;
      end
    endfunction

    function void check_result(logic [WORD_W-1:0] v, logic [1:0] s);
      eval_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: result with nothing expected: value %0d status %0d",
                   $time, $signed(v), s);
        return;
      end
      want = awaited.pop_front();
      if (v !== want.value) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: value mismatch: expected %0d, got %0d",
                   $time, $signed(want.value), $signed(v));
      end
      if (s !== want.status) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, s);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [7:0]               character;
  logic                     last;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [WORD_W-1:0] value;
  logic [1:0]               status;

  postfix_tracker sb;
  logic [7:0]     expr_buf[$];
  int             items_sent  = 0;
  int             in_gap_max  = 10;
  int             out_gap_max = 10;
  int             idle_cycles = 0;

  postfix_stack_evaluator u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .character (character),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready === 1'b1) sb.note_char(character, last);
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) sb.check_result(value, status);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random back-pressure per transaction
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = $urandom_range(0, out_gap_max);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic send_char(logic [7:0] c, logic is_last);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    character <= c;
    last      <= is_last;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic send_expr();
    foreach (expr_buf[i]) send_char(expr_buf[i], i == expr_buf.size() - 1);
  endtask

  task automatic run_text(string s);
    expr_buf.delete();
    for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
    send_expr();
  endtask

  // input side goes quiet while the results drain
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_CARET;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // leaves lean toward 0, 1 and negatives so that negative powers and
  // division by zero come up often
  function automatic void grow_leaf();
    case ($urandom_range(0, 9))
      6: expr_buf.push_back(CH_ZERO);
      7: begin
        expr_buf.push_back(CH_ZERO);
        expr_buf.push_back(CH_ZERO + 8'd1);
        expr_buf.push_back(CH_MINUS);
      end
      8: expr_buf.push_back(CH_ZERO + 8'd1);
      9: begin
        expr_buf.push_back(pick_digit());
        expr_buf.push_back(CH_NINE);
        expr_buf.push_back(CH_STAR);
        expr_buf.push_back(CH_NINE);
        expr_buf.push_back(CH_STAR);
      end
      default: expr_buf.push_back(pick_digit());
    endcase
  endfunction

  function automatic void grow_tree(int depth);
    if (depth == 0 || $urandom_range(0, 3) == 0) begin
      grow_leaf();
    end else begin
      grow_tree(depth - 1);
      grow_tree(depth - 1);
      expr_buf.push_back(pick_op());
    end
  endfunction

  function automatic void build_random_expr();
    int kind, n;
    expr_buf.delete();
    kind = $urandom_range(0, 39);
    if (kind < 30) begin
      grow_tree($urandom_range(1, 4));
    end else if (kind < 32) begin
      // run up to and past the stack depth
      n = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 6);
      repeat (n) expr_buf.push_back(pick_digit());
      repeat ($urandom_range(0, 3)) expr_buf.push_back(pick_op());
    end else if (kind < 36) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0)
          expr_buf.push_back(8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 1) == 0)
          expr_buf.push_back(pick_digit());
        else
          expr_buf.push_back(pick_op());
      end
    end else if (kind < 38) begin
      grow_tree($urandom_range(1, 3));
      expr_buf.insert($urandom_range(0, expr_buf.size()), 8'($urandom_range(0, 255)));
    end else begin
      // operators mostly outrun operands, so pops often hit the empty stack
      n = $urandom_range(1, 10);
      repeat (n) expr_buf.push_back(($urandom_range(0, 2) == 0) ? pick_digit() : pick_op());
    end
  endfunction

  initial begin
    in_valid  = 1'b0;
    character = 8'h00;
    last      = 1'b0;
    rst       = 1'b1;
    sb        = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_text("+");            // both pops from an empty stack
    run_text("98+");
    run_text("70/");          // division by zero
    run_text("00^");          // zero to the zero
    run_text("248*1-^01-/");  // most negative divided by minus one
    expr_buf = '{8'h00, 8'hff};
    send_expr();
    items_sent = 23;

    wait_drained();

    for (int seg = 0; seg < 4; seg++) begin
      in_gap_max  = (seg == 1 || seg == 3) ? 0 : 10;
      out_gap_max = (seg == 1 || seg == 2) ? 0 : 10;
      if (seg == 2) wait_drained();
      while (items_sent < (seg + 1) * ITEM_TARGET / 4) begin
        build_random_expr();
        // every character is a transaction, even those the block ignores
        items_sent += expr_buf.size();
        send_expr();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[postfix_stack_evaluator.f]
rtl/core/pse_pkg.sv
rtl/core/pse_ram.sv
rtl/core/pse_alu.sv
rtl/core/postfix_stack_evaluator.sv
tb/sv/testbench.sv
